FILE: rtl/vgapp_pkg.sv
// ----------------------------------------------------------------------------
// vgapp_pkg: shared definitions for the VGA planar port model
// Sizes, port numbers, opcodes and the pipeline record of the core.
// ----------------------------------------------------------------------------
package vgapp_pkg;

  // Plane store depth in words (one byte per plane per word), power of two.
  localparam int unsigned PLANE_BYTES = 65536;
  localparam int unsigned PLANE_AW    = $clog2(PLANE_BYTES);

  // Planar memory window.
  localparam logic [19:0] WIN_LOW  = 20'hA0000;
  localparam logic [19:0] WIN_HIGH = 20'hB0000;

  // I/O port numbers.
  localparam logic [15:0] PORT_SEQ_INDEX = 16'h03C4;
  localparam logic [15:0] PORT_SEQ_DATA  = 16'h03C5;
  localparam logic [15:0] PORT_DAC_WADDR = 16'h03C8;
  localparam logic [15:0] PORT_DAC_DATA  = 16'h03C9;
  localparam logic [15:0] PORT_GFX_INDEX = 16'h03CE;
  localparam logic [15:0] PORT_GFX_DATA  = 16'h03CF;
  localparam logic [15:0] PORT_STATUS    = 16'h03DA;

  // Register indexes behind the index ports.
  localparam logic [7:0] SEQ_MAP_MASK  = 8'h02;
  localparam logic [7:0] SEQ_MEM_MODE  = 8'h04;
  localparam logic [7:0] GFX_READ_MAP  = 8'h04;

  // Fixed read values and masks.
  localparam logic [7:0] STATUS_TOGGLE  = 8'h09;
  localparam logic [7:0] DAC_READ_VALUE = 8'h3F;
  localparam logic [7:0] OPEN_BUS_VALUE = 8'hFF;
  localparam logic [7:0] GFX_READ_VALUE = 8'h00;
  localparam logic [7:0] MAP_MASK_RESET = 8'h0F;
  localparam int unsigned CHAIN4_BIT    = 3;
  localparam logic [1:0] DAC_LAST_CHANNEL = 2'd2;

  typedef enum logic [1:0] {
    OP_PORT_WR = 2'd0,
    OP_PORT_RD = 2'd1,
    OP_MEM_WR  = 2'd2,
    OP_MEM_RD  = 2'd3
  } opcode_e;

  // Result record held while the plane memory read completes.
  typedef struct packed {
    logic [7:0] read_data;
    logic       handled;
    logic       dac_written;
    logic [7:0] dac_entry;
    logic [1:0] dac_channel;
    logic       mem_rd;
    logic [1:0] plane_sel;
  } stage_t;

endpackage

FILE: rtl/vga_planar_port_model_core.sv
// ----------------------------------------------------------------------------
// vga_planar_port_model_core: VGA port registers and unchained planar memory
// Decodes CPU bus beats against the sequencer, graphics, DAC and status
// ports and serves planar memory writes and reads in the A0000 window.
// ----------------------------------------------------------------------------
// One beat is accepted per clock cycle unless held off by the clearing pass
// or a stalled output; its result passes the plane memory read and result
// record stage, then the output register. The plane memory has byte-lane
// write enables, so a memory write stores only the enabled planes and needs
// no read-back, and a read in the cycle after a write to the same word already
// sees the new data. After reset a clearing pass zeroes one word per cycle
// through all PLANE_BYTES (65536) words; no input beat is accepted meanwhile.
// Palette writes are reported on the result only, since the palette is never
// read through this interface.
// ----------------------------------------------------------------------------
module vga_planar_port_model_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: port[15:0], address[35:16], data[43:36], zero fill[47:44]
  input  logic [47:0] s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: read_data[7:0], handled[8], dac_written[9], dac_entry[17:10],
  //        dac_channel[19:18], zero fill[23:20]
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned Aw = vgapp_pkg::PLANE_AW;

  // Input field split.
  vgapp_pkg::opcode_e op;
  logic [15:0] in_port;
  logic [19:0] in_addr;
  logic [7:0]  in_data;

  assign op      = vgapp_pkg::opcode_e'(s_axis_tuser);
  assign in_port = s_axis_tdata[15:0];
  assign in_addr = s_axis_tdata[35:16];
  assign in_data = s_axis_tdata[43:36];

  // Port registers.
  logic [7:0] seq_index_q, seq_index_d;
  logic [7:0] gfx_index_q, gfx_index_d;
  logic [7:0] map_mask_q, map_mask_d;
  logic       chained_q, chained_d;
  logic [1:0] read_plane_q, read_plane_d;
  logic [7:0] dac_entry_q, dac_entry_d;
  logic [1:0] dac_chan_q, dac_chan_d;
  logic [7:0] status_q, status_d;

  // Pipeline and clearing control.
  logic          clr_busy_q;
  logic [Aw-1:0] clr_addr_q;
  logic          s1_valid_q;
  vgapp_pkg::stage_t s1_q, s1_d;
  logic          out_valid_q;
  logic [23:0]   out_data_q;

  logic accept;
  logic advance;
  logic in_win;
  logic mem_we;
  logic mem_re;
  logic [Aw-1:0] mem_addr;
  logic [3:0]    mem_lane_we;
  logic [3:0][7:0] mem_wdata;

  // Plane memory with its registered read port.
  logic [3:0][7:0] plane_mem [vgapp_pkg::PLANE_BYTES];
  logic [3:0][7:0] rd_word_q;

  // Handshake: the result record moves on when the output register is free.
  assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clr_busy_q && (!s1_valid_q || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_win = (in_addr >= vgapp_pkg::WIN_LOW) && (in_addr < vgapp_pkg::WIN_HIGH) &&
                  !chained_q;

  // Decode of one beat against the current register state.
  always_comb begin
    seq_index_d  = seq_index_q;
    gfx_index_d  = gfx_index_q;
    map_mask_d   = map_mask_q;
    chained_d    = chained_q;
    read_plane_d = read_plane_q;
    dac_entry_d  = dac_entry_q;
    dac_chan_d   = dac_chan_q;
    status_d     = status_q;
    s1_d         = '0;
    s1_d.plane_sel = read_plane_q;
    unique case (op)
      vgapp_pkg::OP_PORT_WR: begin
        s1_d.handled = 1'b1;
        unique case (in_port)
          vgapp_pkg::PORT_SEQ_INDEX: seq_index_d = in_data;
          vgapp_pkg::PORT_SEQ_DATA: begin
            if (seq_index_q == vgapp_pkg::SEQ_MAP_MASK) map_mask_d = in_data;
            if (seq_index_q == vgapp_pkg::SEQ_MEM_MODE) begin
              chained_d = in_data[vgapp_pkg::CHAIN4_BIT];
            end
          end
          vgapp_pkg::PORT_GFX_INDEX: gfx_index_d = in_data;
          vgapp_pkg::PORT_GFX_DATA: begin
            if (gfx_index_q == vgapp_pkg::GFX_READ_MAP) read_plane_d = in_data[1:0];
          end
          vgapp_pkg::PORT_DAC_WADDR: begin
            dac_entry_d = in_data;
            dac_chan_d  = 2'd0;
          end
          vgapp_pkg::PORT_DAC_DATA: begin
            s1_d.dac_written = 1'b1;
            s1_d.dac_entry   = dac_entry_q;
            s1_d.dac_channel = dac_chan_q;
            if (dac_chan_q >= vgapp_pkg::DAC_LAST_CHANNEL) begin
              dac_chan_d  = 2'd0;
              dac_entry_d = dac_entry_q + 8'd1;
            end else begin
              dac_chan_d = dac_chan_q + 2'd1;
            end
          end
          default: ;
        endcase
      end
      vgapp_pkg::OP_PORT_RD: begin
        s1_d.handled = 1'b1;
        unique case (in_port)
          vgapp_pkg::PORT_STATUS: begin
            status_d       = status_q ^ vgapp_pkg::STATUS_TOGGLE;
            s1_d.read_data = status_q ^ vgapp_pkg::STATUS_TOGGLE;
          end
          vgapp_pkg::PORT_SEQ_DATA: s1_d.read_data = map_mask_q;
          vgapp_pkg::PORT_GFX_DATA: s1_d.read_data = vgapp_pkg::GFX_READ_VALUE;
          vgapp_pkg::PORT_DAC_DATA: s1_d.read_data = vgapp_pkg::DAC_READ_VALUE;
          default:                  s1_d.read_data = vgapp_pkg::OPEN_BUS_VALUE;
        endcase
      end
      vgapp_pkg::OP_MEM_WR: s1_d.handled = in_win;
      vgapp_pkg::OP_MEM_RD: begin
        s1_d.handled = in_win;
        s1_d.mem_rd  = in_win;
      end
      default: ;
    endcase
  end

  // Memory port selection: the clearing pass owns the port after reset.
  assign mem_we      = clr_busy_q || (accept && (op == vgapp_pkg::OP_MEM_WR) && in_win);
  assign mem_re      = accept && (op == vgapp_pkg::OP_MEM_RD) && in_win;
  assign mem_addr    = clr_busy_q ? clr_addr_q : in_addr[Aw-1:0];
  assign mem_lane_we = clr_busy_q ? 4'hF : map_mask_q[3:0];
  assign mem_wdata   = clr_busy_q ? '0 : {4{in_data}};

  // Plane memory write with byte lanes, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int i = 0; i < 4; i++) begin
        if (mem_lane_we[i]) plane_mem[mem_addr][i] <= mem_wdata[i];
      end
    end
    if (mem_re) rd_word_q <= plane_mem[mem_addr];
  end

  // Clearing pass after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + Aw'(1);
      if (clr_addr_q == Aw'(vgapp_pkg::PLANE_BYTES - 1)) clr_busy_q <= 1'b0;
    end
  end

  // Port registers update on each accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_index_q  <= '0;
      gfx_index_q  <= '0;
      map_mask_q   <= vgapp_pkg::MAP_MASK_RESET;
      chained_q    <= 1'b1;
      read_plane_q <= '0;
      dac_entry_q  <= '0;
      dac_chan_q   <= '0;
      status_q     <= '0;
    end else if (accept) begin
      seq_index_q  <= seq_index_d;
      gfx_index_q  <= gfx_index_d;
      map_mask_q   <= map_mask_d;
      chained_q    <= chained_d;
      read_plane_q <= read_plane_d;
      dac_entry_q  <= dac_entry_d;
      dac_chan_q   <= dac_chan_d;
      status_q     <= status_d;
    end
  end

  // Result record stage, aligned with the memory read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_q <= s1_d;
  end

  // Final read byte: the selected plane for a planar read.
  logic [7:0] rd_byte;
  assign rd_byte = s1_q.mem_rd ? rd_word_q[s1_q.plane_sel] : s1_q.read_data;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {4'd0, s1_q.dac_channel, s1_q.dac_entry, s1_q.dac_written,
                     s1_q.handled, rd_byte};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: test/tb_vga_planar_port_model_core.sv
// ----------------------------------------------------------------------------
// tb_vga_planar_port_model_core: bus-access testbench for the VGA port model
// Sends port and memory beats, predicts every result with a behavioral copy
// of the port registers and plane memory, and checks each result field.
// ----------------------------------------------------------------------------
module tb_vga_planar_port_model_core;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned POOL_WORDS   = 64;
  localparam int unsigned PLANE_AW     = vgapp_pkg::PLANE_AW;

  // Fields of one result beat, in the order of the output bus.
  typedef struct packed {
    logic [1:0] dac_channel;
    logic [7:0] dac_entry;
    logic       dac_written;
    logic       handled;
    logic [7:0] read_data;
  } bus_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // tdata: port[15:0], address[35:16], data[43:36], zero fill[47:44]
  logic [47:0] s_axis_tdata;
  // tuser: opcode[1:0]
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: read_data[7:0], handled[8], dac_written[9], dac_entry[17:10],
  //        dac_channel[19:18], zero fill[23:20]
  logic [23:0] m_axis_tdata;

  vga_planar_port_model_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // Predicted adapter state. The palette contents are never visible on the
  // result, so only the DAC write pointer is tracked.
  logic [7:0]  seq_index   = '0;
  logic [7:0]  gfx_index   = '0;
  logic [7:0]  map_mask    = vgapp_pkg::MAP_MASK_RESET;
  logic        chain4_on   = 1'b1;
  logic [1:0]  read_plane  = '0;
  logic [7:0]  dac_ptr     = '0;
  logic [1:0]  dac_chan    = '0;
  logic [7:0]  status_reg  = '0;
  logic [31:0] plane_words [vgapp_pkg::PLANE_BYTES];

  bus_result_t expected_results[$];
  int unsigned mismatches    = 0;
  int unsigned beats_sent    = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_left     = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  bit          send_quiet    = 1'b0;
  bit          recv_quiet    = 1'b0;

  // Applies one bus access to the predicted state and returns its result.
  function automatic bus_result_t predict_access(vgapp_pkg::opcode_e op,
                                                 logic [15:0] port,
                                                 logic [19:0] addr, logic [7:0] data);
    bus_result_t         res;
    logic [PLANE_AW-1:0] word_idx;
    res = '0;
    case (op)
      vgapp_pkg::OP_PORT_WR: begin
        res.handled = 1'b1;
        case (port)
          vgapp_pkg::PORT_SEQ_INDEX: seq_index = data;
          vgapp_pkg::PORT_SEQ_DATA: begin
            if (seq_index == vgapp_pkg::SEQ_MAP_MASK) map_mask = data;
            if (seq_index == vgapp_pkg::SEQ_MEM_MODE) begin
              chain4_on = data[vgapp_pkg::CHAIN4_BIT];
            end
          end
          vgapp_pkg::PORT_GFX_INDEX: gfx_index = data;
          vgapp_pkg::PORT_GFX_DATA: begin
            if (gfx_index == vgapp_pkg::GFX_READ_MAP) read_plane = data[1:0];
          end
          vgapp_pkg::PORT_DAC_WADDR: begin
            dac_ptr  = data;
            dac_chan = '0;
          end
          vgapp_pkg::PORT_DAC_DATA: begin
            res.dac_written = 1'b1;
            res.dac_entry   = dac_ptr;
            res.dac_channel = dac_chan;
            // Red, green, blue, then on to the next entry.
            if (dac_chan == vgapp_pkg::DAC_LAST_CHANNEL) begin
              dac_chan = '0;
              dac_ptr  = dac_ptr + 8'd1;
            end else begin
              dac_chan = dac_chan + 2'd1;
            end
          end
          default: ;
        endcase
      end
      vgapp_pkg::OP_PORT_RD: begin
        res.handled = 1'b1;
        case (port)
          vgapp_pkg::PORT_STATUS: begin
            status_reg    = status_reg ^ vgapp_pkg::STATUS_TOGGLE;
            res.read_data = status_reg;
          end
          vgapp_pkg::PORT_SEQ_DATA: res.read_data = map_mask;
          vgapp_pkg::PORT_GFX_DATA: res.read_data = vgapp_pkg::GFX_READ_VALUE;
          vgapp_pkg::PORT_DAC_DATA: res.read_data = vgapp_pkg::DAC_READ_VALUE;
          default:                  res.read_data = vgapp_pkg::OPEN_BUS_VALUE;
        endcase
      end
      default: begin
        // Memory beats are only taken inside the window with chain-4 off.
        if (addr >= vgapp_pkg::WIN_LOW && addr < vgapp_pkg::WIN_HIGH && !chain4_on) begin
          res.handled = 1'b1;
          word_idx = PLANE_AW'(addr - vgapp_pkg::WIN_LOW);
          if (op == vgapp_pkg::OP_MEM_WR) begin
            for (int p = 0; p < 4; p++) begin
              if (map_mask[p]) plane_words[word_idx][8*p +: 8] = data;
            end
          end else begin
            res.read_data = plane_words[word_idx][8*read_plane +: 8];
          end
        end
      end
    endcase
    return res;
  endfunction

  // Offers one beat after a random gap and records its predicted result.
  task automatic send_beat(input vgapp_pkg::opcode_e op, input logic [15:0] port,
                           input logic [19:0] addr, input logic [7:0] data);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, data, addr, port};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_access(op, port, addr, data));
    beats_sent++;
  endtask

  // Window address, mostly from a small pool of words so reads hit writes.
  function automatic logic [19:0] window_addr();
    logic [15:0] offset;
    offset = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, POOL_WORDS - 1))
                                        : 16'($urandom_range(0, 16'hFFFF));
    return vgapp_pkg::WIN_LOW + 20'(offset);
  endfunction

  // Register ports, open bus and accesses while memory is still chained.
  task automatic test_port_registers();
    send_beat(vgapp_pkg::OP_PORT_RD, vgapp_pkg::PORT_STATUS, '0, '0);
    send_beat(vgapp_pkg::OP_PORT_RD, vgapp_pkg::PORT_STATUS, '1, '1);
    send_beat(vgapp_pkg::OP_PORT_RD, 16'h0000, '0, '0);
    send_beat(vgapp_pkg::OP_PORT_RD, 16'hFFFF, '1, '1);
    send_beat(vgapp_pkg::OP_PORT_RD, vgapp_pkg::PORT_DAC_DATA, '0, '0);
    send_beat(vgapp_pkg::OP_PORT_RD, vgapp_pkg::PORT_GFX_DATA, '0, '0);
    send_beat(vgapp_pkg::OP_PORT_WR, 16'hFFFF, '1, 8'hFF);
    send_beat(vgapp_pkg::OP_MEM_WR, '0, vgapp_pkg::WIN_LOW, 8'h5A);
    send_beat(vgapp_pkg::OP_MEM_RD, '0, vgapp_pkg::WIN_LOW, '0);
    // The upper bits of the map mask are kept and read back.
    send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_SEQ_INDEX, '0,
              vgapp_pkg::SEQ_MAP_MASK);
    send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_SEQ_DATA, '0, 8'hF5);
    send_beat(vgapp_pkg::OP_PORT_RD, vgapp_pkg::PORT_SEQ_DATA, '0, '0);
  endtask

  // Unchained planar writes and reads at the window edges and just outside.
  task automatic test_planar_window();
    send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_SEQ_INDEX, '0,
              vgapp_pkg::SEQ_MEM_MODE);
    send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_SEQ_DATA, '0, 8'hF7);
    send_beat(vgapp_pkg::OP_MEM_WR, '0, vgapp_pkg::WIN_LOW, 8'hAA);
    send_beat(vgapp_pkg::OP_MEM_WR, '0, vgapp_pkg::WIN_HIGH - 20'd1, 8'h55);
    send_beat(vgapp_pkg::OP_MEM_WR, '0, vgapp_pkg::WIN_LOW - 20'd1, 8'hFF);
    send_beat(vgapp_pkg::OP_MEM_WR, '0, vgapp_pkg::WIN_HIGH, 8'hFF);
    send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_GFX_INDEX, '0,
              vgapp_pkg::GFX_READ_MAP);
    send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_GFX_DATA, '0, 8'hFE);
    send_beat(vgapp_pkg::OP_MEM_RD, '0, vgapp_pkg::WIN_LOW, '0);
    send_beat(vgapp_pkg::OP_MEM_RD, '0, vgapp_pkg::WIN_HIGH - 20'd1, '0);
    send_beat(vgapp_pkg::OP_MEM_RD, '0, 20'hFFFFF, '0);
  endtask

  // DAC pointer wrapping from the last entry back to the first.
  task automatic test_palette_wrap();
    send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_DAC_WADDR, '0, 8'hFF);
    repeat (4) begin
      send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_DAC_DATA, '0,
                8'($urandom_range(0, 255)));
    end
    send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_DAC_WADDR, '0, 8'h00);
    send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_DAC_DATA, '0, 8'h3F);
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_output_backpressure();
    send_quiet = 1'b1;
    hold_requests++;
    repeat (40) send_beat(vgapp_pkg::OP_MEM_RD, '0, window_addr(), '0);
    send_quiet = 1'b0;
  endtask

  // Mostly well-formed register sequences and planar traffic, with noise.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    goal = beats_sent + count;
    while (beats_sent < goal) begin
      // Change the idling style every few dozen beats.
      if (beats_sent % 64 == 0) begin
        send_quiet = ($urandom_range(0, 3) == 0);
        recv_quiet = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_beat(vgapp_pkg::OP_MEM_WR, 16'($urandom()), window_addr(), 8'($urandom()));
      end else if (pick < 55) begin
        send_beat(vgapp_pkg::OP_MEM_RD, 16'($urandom()), window_addr(), 8'($urandom()));
      end else if (pick < 62) begin
        send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_SEQ_INDEX, 20'($urandom()),
                  vgapp_pkg::SEQ_MAP_MASK);
        send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_SEQ_DATA, 20'($urandom()),
                  8'($urandom()));
      end else if (pick < 68) begin
        send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_GFX_INDEX, 20'($urandom()),
                  vgapp_pkg::GFX_READ_MAP);
        send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_GFX_DATA, 20'($urandom()),
                  8'($urandom()));
      end else if (pick < 71) begin
        // Chain-4 is set again now and then, mostly cleared.
        send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_SEQ_INDEX, 20'($urandom()),
                  vgapp_pkg::SEQ_MEM_MODE);
        send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_SEQ_DATA, 20'($urandom()),
                  8'($urandom()) & ~8'h08 | (($urandom_range(0, 3) == 0) ? 8'h08 : 8'h00));
      end else if (pick < 80) begin
        if ($urandom_range(0, 1)) begin
          send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_DAC_WADDR, 20'($urandom()),
                    8'($urandom()));
        end
        repeat ($urandom_range(1, 6)) begin
          send_beat(vgapp_pkg::OP_PORT_WR, vgapp_pkg::PORT_DAC_DATA, 20'($urandom()),
                    8'($urandom()));
        end
      end else if (pick < 87) begin
        case ($urandom_range(0, 3))
          0: send_beat(vgapp_pkg::OP_PORT_RD, vgapp_pkg::PORT_STATUS, 20'($urandom()),
                       8'($urandom()));
          1: send_beat(vgapp_pkg::OP_PORT_RD, vgapp_pkg::PORT_SEQ_DATA, 20'($urandom()),
                       8'($urandom()));
          2: send_beat(vgapp_pkg::OP_PORT_RD, vgapp_pkg::PORT_GFX_DATA, 20'($urandom()),
                       8'($urandom()));
          default: send_beat(vgapp_pkg::OP_PORT_RD, vgapp_pkg::PORT_DAC_DATA,
                             20'($urandom()), 8'($urandom()));
        endcase
      end else begin
        // Noise: any opcode, any port, any address.
        send_beat(vgapp_pkg::opcode_e'($urandom_range(0, 3)),
                  $urandom_range(0, 1) ? 16'($urandom())
                                       : (16'h03C0 | 16'($urandom_range(0, 31))),
                  20'($urandom()), 8'($urandom()));
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, result checks.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expected result: tdata %0h", m_axis_tdata);
          mismatches++;
        end else begin
          bus_result_t want;
          bus_result_t got;
          want = expected_results.pop_front();
          got  = bus_result_t'(m_axis_tdata[19:0]);
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
            mismatches++;
          end
          if (got.handled !== want.handled) begin
            $error("handled: expected %0h, got %0h", want.handled, got.handled);
            mismatches++;
          end
          if (got.dac_written !== want.dac_written) begin
            $error("dac_written: expected %0h, got %0h", want.dac_written,
                   got.dac_written);
            mismatches++;
          end
          if (got.dac_entry !== want.dac_entry) begin
            $error("dac_entry: expected %0h, got %0h", want.dac_entry, got.dac_entry);
            mismatches++;
          end
          if (got.dac_channel !== want.dac_channel) begin
            $error("dac_channel: expected %0h, got %0h", want.dac_channel,
                   got.dac_channel);
            mismatches++;
          end
        end
        hold_left = recv_quiet ? 0 : $urandom_range(0, 9);
      end
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends a run that hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    foreach (plane_words[i]) plane_words[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_port_registers();
    test_planar_window();
    test_palette_wrap();
    test_output_backpressure();
    test_random_traffic(1300);
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding results, then watch for stray beats.
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
